// File: rtl/core/irc_lex_pkg.sv
// Shared types, character codes and grammar check for the IRC message lexer.
`default_nettype none

package irc_lex_pkg;

    typedef enum logic [3:0] {
        ST_NONE    = 4'd0,
        ST_PREFIX  = 4'd1,
        ST_USER    = 4'd2,
        ST_HOST    = 4'd3,
        ST_CMD     = 4'd4,
        ST_CMD_NUM = 4'd5,
        ST_CMD_LET = 4'd6,
        ST_PARAMS  = 4'd7,
        ST_TRAIL   = 4'd8,
        ST_CR      = 4'd9
    } lex_state_t;

    typedef enum logic [2:0] {
        K_LF     = 3'd0,
        K_SERVER = 3'd1,
        K_NICK   = 3'd2,
        K_USER   = 3'd3,
        K_HOST   = 3'd4,
        K_CMD    = 3'd5,
        K_PARAM  = 3'd6,
        K_CR     = 3'd7
    } kind_t;

    localparam logic [2:0] ROLE_NONE   = 3'd0;
    localparam logic [2:0] ROLE_PREFIX = 3'd1;
    localparam logic [2:0] ROLE_USER   = 3'd2;
    localparam logic [2:0] ROLE_HOST   = 3'd3;
    localparam logic [2:0] ROLE_CMD    = 3'd4;
    localparam logic [2:0] ROLE_PARAM  = 3'd5;

    localparam logic [2:0] CLOSED_NONE = 3'd0;

    localparam logic [1:0] LINE_NONE = 2'd0;
    localparam logic [1:0] LINE_CR   = 2'd1;
    localparam logic [1:0] LINE_LF   = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AT    = 8'h40;

    localparam logic [3:0] PARAMS_MAX = 4'hf;

    // lexer context carried from one byte to the next
    typedef struct packed {
        lex_state_t  lex;
        kind_t       last;
        logic [3:0]  params;
    } lex_ctx_t;

    // one result item, less the echoed byte
    typedef struct packed {
        logic [2:0]  role;
        logic [2:0]  kind;
        logic [9:0]  length;
        logic        acc;
        logic [1:0]  line;
        logic        done;
        logic [3:0]  params;
        logic        err;
    } lex_res_t;

    typedef struct packed {
        logic        acc;
        logic        err;
        logic        done;
        logic [3:0]  params;
        kind_t       last;
    } gram_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    // Check one token or line event against the previous token kind.
    function automatic gram_t grammar_check(kind_t last, kind_t t, logic [3:0] params);
        gram_t g;
        g.acc    = 1'b0;
        g.err    = 1'b0;
        g.done   = 1'b0;
        g.params = params;
        g.last   = t;
        unique case (last)
            K_LF:     g.acc = (t == K_SERVER) || (t == K_NICK) || (t == K_CMD);
            K_SERVER: g.acc = (t == K_CMD);
            K_NICK:   g.acc = (t == K_USER) || (t == K_HOST) || (t == K_CMD);
            K_USER:   g.acc = (t == K_HOST) || (t == K_CMD);
            K_HOST:   g.acc = (t == K_CMD);
            default:  g.acc = 1'b0;
        endcase
        if (last <= K_HOST) begin
            g.err = !g.acc;
        end
        else if ((last == K_CMD) || (last == K_PARAM)) begin
            if (t == K_PARAM) begin
                g.acc = 1'b1;
                if (params < PARAMS_MAX)
                    g.params = params + 4'd1;
            end
            else if (t == K_LF) begin
                g.done = 1'b1;
            end
            else if (t != K_CR) begin
                g.err = 1'b1;
            end
        end
        else begin
            g.done = (t == K_LF);
        end
        return g;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/irc_lex_step.sv
// Per-byte lexer decision: next context, token length and result item.
`default_nettype none

module irc_lex_step #(
    parameter int MAX_TOKEN_LEN = 512
) (
    input  wire logic [7:0]                           data_byte,
    input  wire irc_lex_pkg::lex_ctx_t                ctx,
    input  wire logic [$clog2(MAX_TOKEN_LEN+1)-1:0]   token_len,
    output irc_lex_pkg::lex_ctx_t                     ctx_next,
    output logic [$clog2(MAX_TOKEN_LEN+1)-1:0]        token_len_next,
    output irc_lex_pkg::lex_res_t                     res
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

    logic                    act_store;
    logic [2:0]              act_role;
    logic                    act_close;
    irc_lex_pkg::kind_t      act_kind;
    logic [1:0]              act_line;
    irc_lex_pkg::lex_state_t lex_next;
    logic                    cmd_match;
    logic                    has_text;
    irc_lex_pkg::gram_t      g_tok;
    irc_lex_pkg::gram_t      g_line;

    assign cmd_match = (ctx.lex == irc_lex_pkg::ST_CMD_NUM) ? irc_lex_pkg::is_digit(data_byte)
                                                            : irc_lex_pkg::is_alpha(data_byte);
    assign has_text  = (token_len != '0);

    // next lexer state
    always_comb
    begin
        lex_next = ctx.lex;
        unique case (ctx.lex)
            irc_lex_pkg::ST_NONE:
                lex_next = (data_byte == irc_lex_pkg::CH_COLON) ? irc_lex_pkg::ST_PREFIX
                                                                : irc_lex_pkg::ST_CMD;
            irc_lex_pkg::ST_PREFIX:
                if (data_byte == irc_lex_pkg::CH_SP)            lex_next = irc_lex_pkg::ST_CMD;
                else if (data_byte == irc_lex_pkg::CH_BANG)     lex_next = irc_lex_pkg::ST_USER;
                else if (data_byte == irc_lex_pkg::CH_AT)       lex_next = irc_lex_pkg::ST_HOST;
            irc_lex_pkg::ST_USER:
                if (data_byte == irc_lex_pkg::CH_SP)            lex_next = irc_lex_pkg::ST_CMD;
                else if (data_byte == irc_lex_pkg::CH_AT)       lex_next = irc_lex_pkg::ST_HOST;
            irc_lex_pkg::ST_HOST:
                if (data_byte == irc_lex_pkg::CH_SP)            lex_next = irc_lex_pkg::ST_CMD;
            irc_lex_pkg::ST_CMD:
                if (irc_lex_pkg::is_digit(data_byte))           lex_next = irc_lex_pkg::ST_CMD_NUM;
                else if (irc_lex_pkg::is_alpha(data_byte))      lex_next = irc_lex_pkg::ST_CMD_LET;
            irc_lex_pkg::ST_CMD_NUM, irc_lex_pkg::ST_CMD_LET:
                if (cmd_match)                                  lex_next = ctx.lex;
                else if (data_byte == irc_lex_pkg::CH_SP)       lex_next = irc_lex_pkg::ST_PARAMS;
                else if (data_byte == irc_lex_pkg::CH_CR)       lex_next = irc_lex_pkg::ST_CR;
                else if (data_byte == irc_lex_pkg::CH_LF)       lex_next = irc_lex_pkg::ST_NONE;
            irc_lex_pkg::ST_PARAMS:
                if (data_byte == irc_lex_pkg::CH_COLON)         lex_next = irc_lex_pkg::ST_TRAIL;
                else if (data_byte == irc_lex_pkg::CH_CR)       lex_next = irc_lex_pkg::ST_CR;
                else if (data_byte == irc_lex_pkg::CH_LF)       lex_next = irc_lex_pkg::ST_NONE;
            irc_lex_pkg::ST_TRAIL:
                if (data_byte == irc_lex_pkg::CH_CR)            lex_next = irc_lex_pkg::ST_CR;
                else if (data_byte == irc_lex_pkg::CH_LF)       lex_next = irc_lex_pkg::ST_NONE;
            irc_lex_pkg::ST_CR:
                if (data_byte == irc_lex_pkg::CH_LF)            lex_next = irc_lex_pkg::ST_NONE;
            default:
                lex_next = irc_lex_pkg::ST_NONE;
        endcase
    end

    // store / close / line actions for this byte
    always_comb
    begin
        act_store = 1'b0;
        act_role  = irc_lex_pkg::ROLE_NONE;
        act_close = 1'b0;
        act_kind  = irc_lex_pkg::K_LF;
        act_line  = irc_lex_pkg::LINE_NONE;
        unique case (ctx.lex)
            irc_lex_pkg::ST_NONE:
                if (data_byte != irc_lex_pkg::CH_COLON)
                begin
                    act_store = 1'b1;
                    act_role  = irc_lex_pkg::ROLE_CMD;
                end
            irc_lex_pkg::ST_PREFIX:
                priority if (data_byte == irc_lex_pkg::CH_SP)
                begin
                    act_close = 1'b1;
                    act_kind  = irc_lex_pkg::K_SERVER;
                end
                else if ((data_byte == irc_lex_pkg::CH_BANG) ||
                         (data_byte == irc_lex_pkg::CH_AT))
                begin
                    act_close = 1'b1;
                    act_kind  = irc_lex_pkg::K_NICK;
                end
                else
                begin
                    act_store = 1'b1;
                    act_role  = irc_lex_pkg::ROLE_PREFIX;
                end
            irc_lex_pkg::ST_USER:
                if ((data_byte == irc_lex_pkg::CH_SP) || (data_byte == irc_lex_pkg::CH_AT))
                begin
                    act_close = 1'b1;
                    act_kind  = irc_lex_pkg::K_USER;
                end
                else
                begin
                    act_store = 1'b1;
                    act_role  = irc_lex_pkg::ROLE_USER;
                end
            irc_lex_pkg::ST_HOST:
                if (data_byte == irc_lex_pkg::CH_SP)
                begin
                    act_close = 1'b1;
                    act_kind  = irc_lex_pkg::K_HOST;
                end
                else
                begin
                    act_store = 1'b1;
                    act_role  = irc_lex_pkg::ROLE_HOST;
                end
            irc_lex_pkg::ST_CMD:
                if (irc_lex_pkg::is_digit(data_byte) || irc_lex_pkg::is_alpha(data_byte))
                begin
                    act_store = 1'b1;
                    act_role  = irc_lex_pkg::ROLE_CMD;
                end
            irc_lex_pkg::ST_CMD_NUM, irc_lex_pkg::ST_CMD_LET:
                if (cmd_match)
                begin
                    act_store = 1'b1;
                    act_role  = irc_lex_pkg::ROLE_CMD;
                end
                else if ((data_byte == irc_lex_pkg::CH_SP) ||
                         (data_byte == irc_lex_pkg::CH_CR) ||
                         (data_byte == irc_lex_pkg::CH_LF))
                begin
                    // CR/LF also end a command with no params
                    act_close = 1'b1;
                    act_kind  = irc_lex_pkg::K_CMD;
                    if (data_byte == irc_lex_pkg::CH_CR)
                        act_line = irc_lex_pkg::LINE_CR;
                    else if (data_byte == irc_lex_pkg::CH_LF)
                        act_line = irc_lex_pkg::LINE_LF;
                end
            irc_lex_pkg::ST_PARAMS:
                if (data_byte == irc_lex_pkg::CH_COLON)
                begin
                    // pending text carries over into the trailing param
                    act_store = 1'b0;
                end
                else if ((data_byte == irc_lex_pkg::CH_SP) ||
                         (data_byte == irc_lex_pkg::CH_CR) ||
                         (data_byte == irc_lex_pkg::CH_LF))
                begin
                    act_close = has_text;
                    act_kind  = irc_lex_pkg::K_PARAM;
                    if (data_byte == irc_lex_pkg::CH_CR)
                        act_line = irc_lex_pkg::LINE_CR;
                    else if (data_byte == irc_lex_pkg::CH_LF)
                        act_line = irc_lex_pkg::LINE_LF;
                end
                else if (data_byte != irc_lex_pkg::CH_NUL)
                begin
                    act_store = 1'b1;
                    act_role  = irc_lex_pkg::ROLE_PARAM;
                end
            irc_lex_pkg::ST_TRAIL:
                if (data_byte == irc_lex_pkg::CH_CR)
                begin
                    act_close = 1'b1;
                    act_kind  = irc_lex_pkg::K_PARAM;
                    act_line  = irc_lex_pkg::LINE_CR;
                end
                else if (data_byte == irc_lex_pkg::CH_LF)
                begin
                    act_close = 1'b1;
                    act_kind  = irc_lex_pkg::K_PARAM;
                    act_line  = irc_lex_pkg::LINE_LF;
                end
                else if (data_byte != irc_lex_pkg::CH_NUL)
                begin
                    act_store = 1'b1;
                    act_role  = irc_lex_pkg::ROLE_PARAM;
                end
            irc_lex_pkg::ST_CR:
                if (data_byte == irc_lex_pkg::CH_LF)
                    act_line = irc_lex_pkg::LINE_LF;
            default:
                act_store = 1'b0;
        endcase
    end

    // token check, then line event check on the updated context
    always_comb
    begin
        g_tok.acc    = 1'b0;
        g_tok.err    = 1'b0;
        g_tok.done   = 1'b0;
        g_tok.params = ctx.params;
        g_tok.last   = ctx.last;
        if (act_close)
            g_tok = irc_lex_pkg::grammar_check(ctx.last, act_kind, ctx.params);

        g_line = g_tok;
        if (act_line != irc_lex_pkg::LINE_NONE)
        begin
            g_line = irc_lex_pkg::grammar_check(
                g_tok.last,
                (act_line == irc_lex_pkg::LINE_CR) ? irc_lex_pkg::K_CR : irc_lex_pkg::K_LF,
                g_tok.params);
            g_line.acc = g_tok.acc;
        end
    end

    always_comb
    begin
        token_len_next = token_len;
        if (act_close)
            token_len_next = '0;
        else if (act_store && (token_len < LEN_W'(MAX_TOKEN_LEN)))
            token_len_next = token_len + LEN_W'(1);
    end

    assign ctx_next.lex    = lex_next;
    assign ctx_next.last   = g_line.last;
    assign ctx_next.params = (g_tok.done || g_line.done) ? 4'd0 : g_line.params;

    assign res.role   = act_role;
    assign res.kind   = act_close ? 3'(act_kind) : irc_lex_pkg::CLOSED_NONE;
    assign res.length = act_close ? 10'(token_len) : 10'd0;
    assign res.acc    = act_close & g_tok.acc;
    assign res.line   = act_line;
    assign res.done   = g_tok.done | g_line.done;
    assign res.params = g_line.params;
    assign res.err    = g_tok.err | g_line.err;

endmodule

`default_nettype wire

// File: rtl/core/irc_message_lexer_core.sv
// IRC message lexer: one raw byte in, one lexer result out.
// Usage:
//   Input channel (in_valid, in_stall, data_byte) carries one byte of the
//   message stream per transfer. Output channel (out_valid, out_stall and
//   the result fields) returns exactly one result per byte, in order.
//   Each result gives the byte's role, the token it closes with its length
//   and grammar verdict, CR/LF events, message completion, the running
//   parameter count and a grammar error flag.
// Timing:
//   The input transfer loads the input register, and the lexer decision
//   loads the result register once the result stage is free. Throughput
//   is one byte per cycle while out_stall is low; the lexer context
//   update is a combinational decision between those two registers.
// Reset:
//   rst_n clears both stages and returns the lexer to start of line with
//   the previous token taken as LF, zero token length and zero params.
// Backpressure:
//   While out_stall is high the result holds. The input register keeps its
//   byte and in_stall rises only when it is full and cannot move on.
`default_nettype none

module irc_message_lexer_core #(
    parameter int MAX_TOKEN_LEN = 512
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       byte_out,
    output logic [2:0]       char_role,
    output logic [2:0]       closed_kind,
    output logic [9:0]       closed_length,
    output logic             closed_accepted,
    output logic [1:0]       line_event,
    output logic             message_done,
    output logic [3:0]       param_count,
    output logic             grammar_error
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    irc_lex_pkg::lex_ctx_t ctx_reg;
    irc_lex_pkg::lex_ctx_t ctx_next;
    logic [LEN_W-1:0]      token_len_reg;
    logic [LEN_W-1:0]      token_len_next;
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    irc_lex_pkg::lex_res_t out_res_reg;
    irc_lex_pkg::lex_res_t res;
    logic                  advance;
    logic                  in_xfer;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    irc_lex_step #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_step (
        .data_byte      (in_byte_reg),
        .ctx            (ctx_reg),
        .token_len      (token_len_reg),
        .ctx_next       (ctx_next),
        .token_len_next (token_len_next),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctx_reg.lex    <= irc_lex_pkg::ST_NONE;
            ctx_reg.last   <= irc_lex_pkg::K_LF;
            ctx_reg.params <= 4'd0;
            token_len_reg <= '0;
        end
        else
        begin
            if (in_xfer)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                ctx_reg       <= ctx_next;
                token_len_reg <= token_len_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            in_byte_reg <= data_byte;
        if (advance)
        begin
            out_byte_reg <= in_byte_reg;
            out_res_reg  <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign byte_out        = out_byte_reg;
    assign char_role       = out_res_reg.role;
    assign closed_kind     = out_res_reg.kind;
    assign closed_length   = out_res_reg.length;
    assign closed_accepted = out_res_reg.acc;
    assign line_event      = out_res_reg.line;
    assign message_done    = out_res_reg.done;
    assign param_count     = out_res_reg.params;
    assign grammar_error   = out_res_reg.err;

    // no token closed means no length and no verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (closed_kind == irc_lex_pkg::CLOSED_NONE)) |->
            ((closed_length == 10'd0) && !closed_accepted))
    else $error("closed fields set with no token closed");

    // a message completes only on a line feed
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && message_done) |-> (line_event == irc_lex_pkg::LINE_LF))
    else $error("message done without line feed");

    // a stored byte never coincides with a token close or line event
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (char_role != irc_lex_pkg::ROLE_NONE)) |->
            ((closed_kind == irc_lex_pkg::CLOSED_NONE) &&
             (line_event == irc_lex_pkg::LINE_NONE)))
    else $error("stored byte also closed a token");

    // completed message clears the parameter count
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.done) |=> (ctx_reg.params == 4'd0))
    else $error("param count not cleared after message");

    // the after-CR state always follows a CR event
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctx_reg.lex == irc_lex_pkg::ST_CR) |-> (ctx_reg.last == irc_lex_pkg::K_CR))
    else $error("after-CR state without CR as last token");

endmodule

`default_nettype wire
